// ===== src/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Shared widths, configuration register indexes and the structure that
// carries a point set from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package mer_pkg;

  // Field and state widths.
  localparam int RadiusW  = 10;
  localparam int CentreW  = 11;
  localparam int PosW     = 11;
  localparam int SqW      = 2 * RadiusW;
  localparam int SlopeW   = 40;
  localparam int DecW     = 48;

  // Shared multiplier operand and product widths.
  localparam int MulW     = 24;
  localparam int ProdW    = 2 * MulW;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = CentreW;

  // Default output coordinate width.
  localparam int CoordBitsDef = 12;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_RADIUS_H = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RADIUS_V = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CENTRE_X = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_CENTRE_Y = 2'd3;

  // One point set handed to the output stage.
  typedef struct packed {
    logic            valid;
    logic            none;
    logic            last;
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
  } emit_t;

endpackage

// ===== src/mer_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 24 x 24 multiplier with a registered 48-bit product.
// ----------------------------------------------------------------------------
module mer_mul (
  input  logic                      clk,
  input  logic [mer_pkg::MulW-1:0]  mul_a,
  input  logic [mer_pkg::MulW-1:0]  mul_b,
  output logic [mer_pkg::ProdW-1:0] mul_p
);

  logic [mer_pkg::ProdW-1:0] prod_r;

  // Product is registered and ready in the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign mul_p = prod_r;

endmodule

// ===== src/mer_core.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse sequencer
// Holds the trace state and walks each beat through a short program of
// multiplies and adds on the shared multiplier.
// ----------------------------------------------------------------------------
module mer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          restart,
  input  logic [mer_pkg::RadiusW-1:0]   radius_h,
  input  logic [mer_pkg::RadiusW-1:0]   radius_v,
  output logic                          busy,
  output logic [mer_pkg::MulW-1:0]      mul_a,
  output logic [mer_pkg::MulW-1:0]      mul_b,
  input  logic [mer_pkg::ProdW-1:0]     mul_p,
  output mer_pkg::emit_t                emit,
  input  logic                          emit_ready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_RST, ST_CHK,
    ST_SD1, ST_SD2, ST_SD3, ST_SD4, ST_SD5,
    ST_EMIT, ST_R1X, ST_R1Y, ST_R2Y, ST_R2X
  } state_t;

  state_t                        state_r,   state_nxt;
  logic                          restart_r, restart_nxt;
  logic [mer_pkg::PosW-1:0]      cur_x_r,   cur_x_nxt;
  logic [mer_pkg::PosW-1:0]      cur_y_r,   cur_y_nxt;
  logic [mer_pkg::DecW-1:0]      dec_r,     dec_nxt;
  logic [mer_pkg::DecW-1:0]      acc_r,     acc_nxt;
  logic [mer_pkg::SlopeW-1:0]    stx_r,     stx_nxt;
  logic [mer_pkg::SlopeW-1:0]    sty_r,     sty_nxt;
  logic [mer_pkg::SqW-1:0]       rx2_r,     rx2_nxt;
  logic [mer_pkg::SqW-1:0]       ry2_r,     ry2_nxt;
  logic                          r2_r,      r2_nxt;
  logic                          fin_r,     fin_nxt;

  logic [mer_pkg::PosW-1:0]      x_inc;
  logic [mer_pkg::PosW-1:0]      y_dec;
  logic [mer_pkg::PosW-1:0]      ym1;
  logic [mer_pkg::PosW:0]        t_odd;
  logic [mer_pkg::PosW-1:0]      y_r1;
  logic [mer_pkg::SlopeW-1:0]    slope_p;
  logic [mer_pkg::DecW-1:0]      prod_x4;
  logic [mer_pkg::DecW-1:0]      slope_x4;
  logic [mer_pkg::DecW-1:0]      r2_sub;

  // Small helpers around the current position and the product.
  assign x_inc    = cur_x_r + 11'd1;
  assign y_dec    = cur_y_r - 11'd1;
  assign ym1      = (cur_y_r == '0) ? 11'd1 : y_dec;
  assign t_odd    = {cur_x_r, 1'b1};
  assign y_r1     = (dec_r[mer_pkg::DecW-1] || cur_y_r == '0) ? cur_y_r : y_dec;
  assign slope_p  = {mul_p[mer_pkg::SlopeW-2:0], 1'b0};
  assign prod_x4  = {mul_p[mer_pkg::DecW-3:0], 2'b00};
  assign slope_x4 = {6'd0, slope_p, 2'b00};
  assign r2_sub   = acc_r - slope_x4;

  assign busy = (state_r != ST_IDLE);

  // Sequencer program.
  always_comb begin
    state_nxt   = state_r;
    restart_nxt = restart_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    dec_nxt     = dec_r;
    acc_nxt     = acc_r;
    stx_nxt     = stx_r;
    sty_nxt     = sty_r;
    rx2_nxt     = rx2_r;
    ry2_nxt     = ry2_r;
    r2_nxt      = r2_r;
    fin_nxt     = fin_r;
    mul_a       = '0;
    mul_b       = '0;
    emit        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          restart_nxt = restart;
          mul_a       = {14'd0, radius_h};
          mul_b       = {14'd0, radius_h};
          state_nxt   = ST_SQX;
        end
      end
      ST_SQX: begin
        rx2_nxt   = mul_p[mer_pkg::SqW-1:0];
        mul_a     = {14'd0, radius_v};
        mul_b     = {14'd0, radius_v};
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        ry2_nxt = mul_p[mer_pkg::SqW-1:0];
        if (restart_r) begin
          // 4*ry^2 + rx^2 now, 4*rx^2*ry taken off next cycle.
          acc_nxt   = prod_x4 + {28'd0, rx2_r};
          mul_a     = {4'd0, rx2_r};
          mul_b     = {14'd0, radius_v};
          state_nxt = ST_RST;
        end else begin
          state_nxt = ST_CHK;
        end
      end
      ST_RST: begin
        cur_x_nxt = '0;
        cur_y_nxt = {1'b0, radius_v};
        stx_nxt   = '0;
        sty_nxt   = slope_p;
        dec_nxt   = acc_r - prod_x4;
        r2_nxt    = 1'b0;
        fin_nxt   = 1'b0;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        // Region switch once the y-slope term no longer exceeds the x-slope term.
        if (!fin_r && !r2_r && !(stx_r < sty_r)) begin
          mul_a     = {12'd0, t_odd};
          mul_b     = {12'd0, t_odd};
          state_nxt = ST_SD1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SD1: begin
        mul_a     = {4'd0, ry2_r};
        mul_b     = mul_p[mer_pkg::MulW-1:0];
        state_nxt = ST_SD2;
      end
      ST_SD2: begin
        acc_nxt   = mul_p;
        mul_a     = {13'd0, ym1};
        mul_b     = {13'd0, ym1};
        state_nxt = ST_SD3;
      end
      ST_SD3: begin
        mul_a     = {4'd0, rx2_r};
        mul_b     = {2'd0, mul_p[21:0]};
        state_nxt = ST_SD4;
      end
      ST_SD4: begin
        acc_nxt   = acc_r + prod_x4;
        mul_a     = {4'd0, rx2_r};
        mul_b     = {4'd0, ry2_r};
        state_nxt = ST_SD5;
      end
      ST_SD5: begin
        dec_nxt   = acc_r - prod_x4;
        r2_nxt    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        emit.valid = 1'b1;
        emit.none  = fin_r;
        emit.last  = !fin_r && r2_r && (cur_y_r == '0);
        emit.x     = cur_x_r;
        emit.y     = cur_y_r;
        if (emit_ready) begin
          if (fin_r) begin
            state_nxt = ST_IDLE;
          end else if (!r2_r) begin
            cur_x_nxt = x_inc;
            mul_a     = {4'd0, ry2_r};
            mul_b     = {13'd0, x_inc};
            state_nxt = ST_R1X;
          end else if (cur_y_r == '0) begin
            fin_nxt   = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cur_y_nxt = y_dec;
            acc_nxt   = dec_r + {26'd0, rx2_r, 2'b00};
            mul_a     = {4'd0, rx2_r};
            mul_b     = {13'd0, y_dec};
            state_nxt = ST_R2Y;
          end
        end
      end
      ST_R1X: begin
        stx_nxt   = slope_p;
        acc_nxt   = dec_r + {5'd0, ({1'b0, slope_p} + {21'd0, ry2_r}), 2'b00};
        cur_y_nxt = y_r1;
        mul_a     = {4'd0, rx2_r};
        mul_b     = {13'd0, y_r1};
        state_nxt = ST_R1Y;
      end
      ST_R1Y: begin
        sty_nxt   = slope_p;
        dec_nxt   = dec_r[mer_pkg::DecW-1] ? acc_r : r2_sub;
        state_nxt = ST_IDLE;
      end
      ST_R2Y: begin
        sty_nxt = slope_p;
        if (!dec_r[mer_pkg::DecW-1] && dec_r != '0) begin
          dec_nxt   = r2_sub;
          state_nxt = ST_IDLE;
        end else begin
          cur_x_nxt = x_inc;
          acc_nxt   = r2_sub;
          mul_a     = {4'd0, ry2_r};
          mul_b     = {13'd0, x_inc};
          state_nxt = ST_R2X;
        end
      end
      ST_R2X: begin
        stx_nxt   = slope_p;
        dec_nxt   = acc_r + slope_x4;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and trace registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cur_x_r <= '0;
      cur_y_r <= '0;
      dec_r   <= '0;
      stx_r   <= '0;
      sty_r   <= '0;
      r2_r    <= 1'b0;
      fin_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      dec_r   <= dec_nxt;
      stx_r   <= stx_nxt;
      sty_r   <= sty_nxt;
      r2_r    <= r2_nxt;
      fin_r   <= fin_nxt;
    end
    restart_r <= restart_nxt;
    acc_r     <= acc_nxt;
    rx2_r     <= rx2_nxt;
    ry2_r     <= ry2_nxt;
  end

endmodule

// ===== src/mer_outreg.sv =====
// ----------------------------------------------------------------------------
// Point set output stage
// Offsets a point set by the centre into four symmetric points and holds
// the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module mer_outreg #(
  parameter int COORD_BITS = mer_pkg::CoordBitsDef
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mer_pkg::emit_t                     emit,
  output logic                               emit_ready,
  input  logic signed [mer_pkg::CentreW-1:0] centre_x,
  input  logic signed [mer_pkg::CentreW-1:0] centre_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [COORD_BITS-1:0]       out_quad1_x,
  output logic signed [COORD_BITS-1:0]       out_quad1_y,
  output logic signed [COORD_BITS-1:0]       out_quad4_x,
  output logic signed [COORD_BITS-1:0]       out_quad4_y,
  output logic signed [COORD_BITS-1:0]       out_quad3_x,
  output logic signed [COORD_BITS-1:0]       out_quad3_y,
  output logic signed [COORD_BITS-1:0]       out_quad2_x,
  output logic signed [COORD_BITS-1:0]       out_quad2_y,
  output logic                               out_last_set,
  output logic                               out_no_points
);

  localparam int ExtW = 32;

  logic                  valid_r;
  logic [COORD_BITS-1:0] px_r, nx_r, py_r, ny_r;
  logic                  last_r, none_r;
  logic [ExtW-1:0]       cx_ext, cy_ext, x_ext, y_ext;
  logic [ExtW-1:0]       px_sum, nx_sum, py_sum, ny_sum;
  logic                  load;

  // Centre plus or minus offset, wrapped to the coordinate width.
  assign cx_ext = {{(ExtW-mer_pkg::CentreW){centre_x[mer_pkg::CentreW-1]}}, centre_x};
  assign cy_ext = {{(ExtW-mer_pkg::CentreW){centre_y[mer_pkg::CentreW-1]}}, centre_y};
  assign x_ext  = {{(ExtW-mer_pkg::PosW){1'b0}}, emit.x};
  assign y_ext  = {{(ExtW-mer_pkg::PosW){1'b0}}, emit.y};
  assign px_sum = cx_ext + x_ext;
  assign nx_sum = cx_ext - x_ext;
  assign py_sum = cy_ext + y_ext;
  assign ny_sum = cy_ext - y_ext;

  assign emit_ready = !valid_r || !out_stall;
  assign load       = emit.valid && emit_ready;

  // Beat valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Payload; a finished trace reads as all zero.
  always_ff @(posedge clk) begin
    if (load) begin
      if (emit.none) begin
        px_r <= '0;
        nx_r <= '0;
        py_r <= '0;
        ny_r <= '0;
      end else begin
        px_r <= px_sum[COORD_BITS-1:0];
        nx_r <= nx_sum[COORD_BITS-1:0];
        py_r <= py_sum[COORD_BITS-1:0];
        ny_r <= ny_sum[COORD_BITS-1:0];
      end
      last_r <= emit.last;
      none_r <= emit.none;
    end
  end

  assign out_valid     = valid_r;
  assign out_quad1_x   = px_r;
  assign out_quad1_y   = py_r;
  assign out_quad4_x   = px_r;
  assign out_quad4_y   = ny_r;
  assign out_quad3_x   = nx_r;
  assign out_quad3_y   = ny_r;
  assign out_quad2_x   = nx_r;
  assign out_quad2_y   = py_r;
  assign out_last_set  = last_r;
  assign out_no_points = none_r;

endmodule

// ===== src/midpoint_ellipse_rasterizer.sv =====
// Sequence: a beat has both radii squared, a restart resets the trace, and a beat that
//   crosses into region 2 also works out its region 2 decision term before its result shows.
// Flow: a new beat is taken only once the last is done, its products passing one after
//   another through the single shared multiplier; a stalled output holds the sequencer.
// Reset: synchronous, active low; config and trace state clear; the trace starts finished.
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Emits one set of four symmetric ellipse points per input beat, tracing
// region 1 and then region 2 with exact integer decision terms.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS = mer_pkg::CoordBitsDef
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mer_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [mer_pkg::CfgDataW-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_BITS-1:0]        out_quad1_x,
  output logic signed [COORD_BITS-1:0]        out_quad1_y,
  output logic signed [COORD_BITS-1:0]        out_quad4_x,
  output logic signed [COORD_BITS-1:0]        out_quad4_y,
  output logic signed [COORD_BITS-1:0]        out_quad3_x,
  output logic signed [COORD_BITS-1:0]        out_quad3_y,
  output logic signed [COORD_BITS-1:0]        out_quad2_x,
  output logic signed [COORD_BITS-1:0]        out_quad2_y,
  output logic                                out_last_set,
  output logic                                out_no_points
);

  logic [mer_pkg::RadiusW-1:0]       radius_h_r;
  logic [mer_pkg::RadiusW-1:0]       radius_v_r;
  logic signed [mer_pkg::CentreW-1:0] centre_x_r;
  logic signed [mer_pkg::CentreW-1:0] centre_y_r;
  logic                              busy;
  logic                              start;
  logic [mer_pkg::MulW-1:0]          mul_a, mul_b;
  logic [mer_pkg::ProdW-1:0]         mul_p;
  mer_pkg::emit_t                    emit;
  logic                              emit_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_h_r <= '0;
      radius_v_r <= '0;
      centre_x_r <= '0;
      centre_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mer_pkg::CFG_RADIUS_H: radius_h_r <= cfg_data[mer_pkg::RadiusW-1:0];
        mer_pkg::CFG_RADIUS_V: radius_v_r <= cfg_data[mer_pkg::RadiusW-1:0];
        mer_pkg::CFG_CENTRE_X: centre_x_r <= cfg_data;
        mer_pkg::CFG_CENTRE_Y: centre_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // One beat is worked on at a time.
  assign in_stall = busy;
  assign start    = in_valid && !busy;

  mer_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  mer_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .restart    (in_restart),
    .radius_h   (radius_h_r),
    .radius_v   (radius_v_r),
    .busy       (busy),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .mul_p      (mul_p),
    .emit       (emit),
    .emit_ready (emit_ready)
  );

  mer_outreg #(
    .COORD_BITS (COORD_BITS)
  ) u_outreg (
    .clk           (clk),
    .rst_n         (rst_n),
    .emit          (emit),
    .emit_ready    (emit_ready),
    .centre_x      (centre_x_r),
    .centre_y      (centre_y_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_quad1_x   (out_quad1_x),
    .out_quad1_y   (out_quad1_y),
    .out_quad4_x   (out_quad4_x),
    .out_quad4_y   (out_quad4_y),
    .out_quad3_x   (out_quad3_x),
    .out_quad3_y   (out_quad3_y),
    .out_quad2_x   (out_quad2_x),
    .out_quad2_y   (out_quad2_y),
    .out_last_set  (out_last_set),
    .out_no_points (out_no_points)
  );

endmodule

// ===== src/mer_chk.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer checker
// Watches the top-level ports for symmetry and sequencing slips.
// ----------------------------------------------------------------------------
module mer_chk #(
  parameter int COORD_BITS = mer_pkg::CoordBitsDef
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_we,
  input logic [mer_pkg::CfgIdxW-1:0]         cfg_index,
  input logic [mer_pkg::CfgDataW-1:0]        cfg_data,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                in_restart,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [COORD_BITS-1:0]        out_quad1_x,
  input logic signed [COORD_BITS-1:0]        out_quad1_y,
  input logic signed [COORD_BITS-1:0]        out_quad4_x,
  input logic signed [COORD_BITS-1:0]        out_quad4_y,
  input logic signed [COORD_BITS-1:0]        out_quad3_x,
  input logic signed [COORD_BITS-1:0]        out_quad3_y,
  input logic signed [COORD_BITS-1:0]        out_quad2_x,
  input logic signed [COORD_BITS-1:0]        out_quad2_y,
  input logic                                out_last_set,
  input logic                                out_no_points
);

  // An accepted beat keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  // The four points of a set mirror each other.
  a_symmetry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_quad1_x == out_quad4_x && out_quad3_x == out_quad2_x &&
                  out_quad1_y == out_quad2_y && out_quad4_y == out_quad3_y)
    else $error("point set is not symmetric");

  // A finished trace reads as all zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_points |-> out_quad1_x == '0 && out_quad1_y == '0 &&
                                   out_quad3_x == '0 && out_quad3_y == '0 &&
                                   !out_last_set)
    else $error("empty result carries data");

  // The final set is a real point set.
  a_last_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_set |-> !out_no_points)
    else $error("final set flagged empty");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_quad1_x) &&
                               $stable(out_quad1_y) && $stable(out_no_points))
    else $error("stalled result beat changed");

endmodule

bind midpoint_ellipse_rasterizer mer_chk #(.COORD_BITS(COORD_BITS)) u_mer_chk (.*);
